### rtl/core/smf_pkg.sv
// shared types, constants and helpers of the sliding median filter
package smf_pkg;

	localparam int SAMPLE_WIDTH       = 16;
	localparam int HALF_WIDTH_W       = 3;
	localparam int HALF_WIDTH_LIMIT   = (1 << HALF_WIDTH_W) - 1;
	localparam int MAX_HALF_WIDTH_DEF = 7;
	localparam int QUEUE_DEPTH        = 2;
	localparam logic [HALF_WIDTH_W-1:0] HALF_WIDTH_RESET = HALF_WIDTH_W'(1);

	// one input sample
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           end_of_signal;
	} in_item_t;

	// one filter result
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] filtered;
		logic                           last_out;
	} out_item_t;

	// classification of one queued job
	typedef struct packed {
		logic [HALF_WIDTH_W-1:0] k;
		logic                    emit_main;
		logic                    is_median;
		logic                    fin;
		logic [HALF_WIDTH_W-1:0] flush_cnt;
	} job_ctl_t;

	// half width reachable with both the register field and the storage
	function automatic int eff_half_width(input int max_hw);
		return (max_hw < HALF_WIDTH_LIMIT) ? max_hw : HALF_WIDTH_LIMIT;
	endfunction

endpackage

### rtl/core/smf_queue.sv
// short job queue between the front and the back of the filter
module smf_queue import smf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNTW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

### rtl/core/smf_front.sv
// front end: sample intake, delay line, position count and job classification
module smf_front import smf_pkg::*; #(
	parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF,
	localparam int WIN = 2 * eff_half_width(MAX_HALF_WIDTH) + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [HALF_WIDTH_W-1:0]           cfg_data,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  in_item_t                          sample_data,
	input  logic                              q_full,
	output logic                              push,
	output logic [WIN-1:0][SAMPLE_WIDTH-1:0]  push_win,
	output job_ctl_t                          push_ctl
);

	localparam int CW   = $clog2(WIN + 1);
	localparam int CMPW = (CW > HALF_WIDTH_W + 1) ? CW : HALF_WIDTH_W + 1;
	localparam logic [HALF_WIDTH_W-1:0] K_CAP = HALF_WIDTH_W'(eff_half_width(MAX_HALF_WIDTH));

	logic [HALF_WIDTH_W-1:0]          half_width_q;
	logic [WIN-1:0][SAMPLE_WIDTH-1:0] dl_q;
	logic [CW-1:0]                    count_q;
	logic [HALF_WIDTH_W-1:0]          k;
	logic [CMPW-1:0]                  n_ext;
	logic [CMPW-1:0]                  k_ext;
	logic [CMPW-1:0]                  k2_ext;
	logic                             n_ge_k;
	logic                             n_ge_2k;
	logic                             accept;
	logic                             fin;

	assign cfg_ready    = 1'b1;
	assign sample_ready = !q_full;
	assign accept       = sample_valid && sample_ready;
	assign fin          = sample_data.end_of_signal;

	// half width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			half_width_q <= cfg_data;
		end
	end

	// position classification
	assign k       = (half_width_q > K_CAP) ? K_CAP : half_width_q;
	assign n_ext   = CMPW'(count_q);
	assign k_ext   = CMPW'(k);
	assign k2_ext  = CMPW'({k, 1'b0});
	assign n_ge_k  = (n_ext >= k_ext);
	assign n_ge_2k = (n_ext >= k2_ext);

	// window after this sample shifts in
	assign push_win = {dl_q[WIN-2:0], sample_data.sample};

	always_comb begin
		push_ctl.k         = k;
		push_ctl.emit_main = n_ge_k;
		push_ctl.is_median = n_ge_2k;
		push_ctl.fin       = fin;
		push_ctl.flush_cnt = n_ge_k ? k : HALF_WIDTH_W'(n_ext + CMPW'(1));
	end

	// only items that produce a result become jobs
	assign push = accept && (n_ge_k || fin);

	// delay line
	always_ff @(posedge clk) begin
		if (accept) begin
			dl_q <= push_win;
		end
	end

	// position count, saturating at the window length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (fin) begin
				count_q <= '0;
			end else if (count_q < CW'(WIN)) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

endmodule

### rtl/core/smf_back.sv
// back end: rank-based median, flush sequencing and output register
module smf_back import smf_pkg::*; #(
	parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF,
	localparam int WIN = 2 * eff_half_width(MAX_HALF_WIDTH) + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  logic [WIN-1:0][SAMPLE_WIDTH-1:0]  head_win,
	input  job_ctl_t                          head_ctl,
	output logic                              pop,
	output logic                              result_valid,
	input  logic                              result_ready,
	output out_item_t                         result_data
);

	localparam int RW = $clog2(WIN);

	logic [WIN-1:0][WIN-1:0]          lt_next;
	logic [WIN-1:0]                   act_next;
	logic [WIN-1:0][SAMPLE_WIDTH-1:0] win_s1;
	logic [WIN-1:0][WIN-1:0]          lt_s1;
	logic [WIN-1:0]                   act_s1;
	job_ctl_t                         ctl_s1;
	logic                             valid_s1;
	logic                             main_pend_s1;
	logic [HALF_WIDTH_W-1:0]          rem_s1;
	logic [WIN-1:0][RW-1:0]           rank;
	logic [WIN-1:0]                   sel;
	logic [SAMPLE_WIDTH-1:0]          median;
	logic [SAMPLE_WIDTH-1:0]          value;
	logic                             last_emit;
	logic                             load;
	logic                             result_valid_q;
	out_item_t                        result_data_q;

	// pairwise order matrix, ties broken by position
	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			act_next[i] = (i <= 2 * int'(head_ctl.k));
			for (int j = 0; j < WIN; j++) begin
				lt_next[i][j] = (j <= 2 * int'(head_ctl.k)) && (j != i) &&
					(($signed(head_win[j]) < $signed(head_win[i])) ||
					 ((head_win[j] == head_win[i]) && (j < i)));
			end
		end
	end

	// rank of each element, median is the one with rank k
	always_comb begin
		median = '0;
		for (int i = 0; i < WIN; i++) begin
			rank[i] = RW'($countones(lt_s1[i]));
			sel[i]  = act_s1[i] && (rank[i] == RW'(ctl_s1.k));
			median  = median | (sel[i] ? win_s1[i] : '0);
		end
	end

	// value of the current emission
	always_comb begin
		if (main_pend_s1) begin
			value = ctl_s1.is_median ? median : win_s1[RW'(ctl_s1.k)];
		end else begin
			value = win_s1[RW'(rem_s1 - HALF_WIDTH_W'(1))];
		end
	end

	assign last_emit = main_pend_s1 ? (rem_s1 == '0) : (rem_s1 == HALF_WIDTH_W'(1));
	assign load      = valid_s1 && (!result_valid_q || result_ready);
	assign pop       = head_valid && (!valid_s1 || (load && last_emit));

	// job stage payload
	always_ff @(posedge clk) begin
		if (pop) begin
			win_s1 <= head_win;
			lt_s1  <= lt_next;
			act_s1 <= act_next;
			ctl_s1 <= head_ctl;
		end
	end

	// job stage sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			main_pend_s1 <= 1'b0;
			rem_s1       <= '0;
		end else if (pop) begin
			valid_s1     <= 1'b1;
			main_pend_s1 <= head_ctl.emit_main;
			rem_s1       <= head_ctl.fin ? head_ctl.flush_cnt : '0;
		end else if (load && last_emit) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			if (main_pend_s1) begin
				main_pend_s1 <= 1'b0;
			end else begin
				rem_s1 <= rem_s1 - HALF_WIDTH_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			result_data_q.filtered <= value;
			result_data_q.last_out <= ctl_s1.fin && last_emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_data_q;

	// a held job always has a result left to give
	a_job_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (main_pend_s1 || (rem_s1 != '0)))
		else $error("job stage holds a job with nothing left to emit");

	// exactly one window element carries the middle rank
	a_median_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && main_pend_s1 && ctl_s1.is_median) |-> $onehot(sel))
		else $error("median select is not one-hot");

	// a job with results left stays in place after a transfer
	a_job_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !last_emit) |=> valid_s1)
		else $error("job left the stage before its last result");

endmodule

### rtl/core/sliding_median_filter_core.sv
// Sliding median filter core. A result passes through the job queue, the job stage and then the output register
// after the sample that completes it. Throughput: one sample per cycle while sample_ready is high; each sample
// yields at most one result except the final one. A final sample holds the result side for a flush of up to k+1
// results; the 2-entry job queue absorbs this, after which sample_ready drops until the flush drains.
// Reset: position count cleared, half width set to 1, delay line contents undefined until written.
module sliding_median_filter_core import smf_pkg::*; #(
	parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [HALF_WIDTH_W-1:0] cfg_data,
	input  logic                    sample_valid,
	output logic                    sample_ready,
	input  in_item_t                sample_data,
	output logic                    result_valid,
	input  logic                    result_ready,
	output out_item_t               result_data
);

	localparam int WIN  = 2 * eff_half_width(MAX_HALF_WIDTH) + 1;
	localparam int CTLW = $bits(job_ctl_t);
	localparam int QW   = WIN * SAMPLE_WIDTH + CTLW;

	logic                             q_full;
	logic                             push;
	logic [WIN-1:0][SAMPLE_WIDTH-1:0] push_win;
	job_ctl_t                         push_ctl;
	logic                             pop;
	logic                             head_valid;
	logic [QW-1:0]                    head_data;
	logic [WIN-1:0][SAMPLE_WIDTH-1:0] head_win;
	job_ctl_t                         head_ctl;

	// intake and classification
	smf_front #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_data  (sample_data),
		.q_full       (q_full),
		.push         (push),
		.push_win     (push_win),
		.push_ctl     (push_ctl)
	);

	// job queue
	smf_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_win, push_ctl}),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign head_win = head_data[QW-1:CTLW];
	assign head_ctl = head_data[CTLW-1:0];

	// median and flush execution
	smf_back #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_win     (head_win),
		.head_ctl     (head_ctl),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

### dv/tb_sliding_median_filter_core.sv
// self-checking testbench for the sliding median filter core
module tb_sliding_median_filter_core;
	import smf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	localparam int TAPS = 2 * MAX_HALF_WIDTH_DEF + 1;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [HALF_WIDTH_W-1:0] cfg_data;
	logic                    sample_valid;
	logic                    sample_ready;
	in_item_t                sample_data;
	logic                    result_valid;
	logic                    result_ready;
	out_item_t               result_data;

	// filter state as the block should hold it
	sample_t                 tap_line [TAPS];
	int                      seen_count;
	logic [HALF_WIDTH_W-1:0] cur_hw;
	out_item_t               pending_outputs [$];

	// bookkeeping
	int                      samples_sent;
	int                      signals_sent;
	int                      outputs_checked;
	int                      fail_count;
	bit                      gaps_on;
	bit                      stall_on;
	int                      stall_left;
	bit [7:0]                hw_seen;

	sliding_median_filter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// sample values biased toward extremes and ties
	function automatic sample_t pick_sample();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		if (r == 1) return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		if (r < 5) return sample_t'($urandom_range(0, 8)) - sample_t'(4);
		return sample_t'($urandom);
	endfunction

	// signal length: mostly around the window size, some past saturation
	function automatic int pick_len(input int k);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2 * k + 4);
		if (r < 90) return $urandom_range(2 * k + 5, 20);
		return $urandom_range(21, 40);
	endfunction

	// sorted middle of the newest len taps
	function automatic sample_t window_mid(input int len);
		sample_t srt [TAPS];
		sample_t v;
		int      i;
		int      j;
		for (i = 0; i < len; i++) begin
			v = tap_line[i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		return srt[len / 2];
	endfunction

	// advance the filter by one sample and queue the outputs it causes
	function automatic void advance_filter(input in_item_t item);
		int        k;
		int        n;
		int        first;
		int        i;
		out_item_t r;
		k = (cur_hw > MAX_HALF_WIDTH_DEF) ? MAX_HALF_WIDTH_DEF : int'(cur_hw);
		n = seen_count;
		for (i = TAPS - 1; i > 0; i--) tap_line[i] = tap_line[i-1];
		tap_line[0] = item.sample;
		// centre position: median once the window is full, raw at the leading edge
		if (n >= k) begin
			r.filtered = (n >= 2 * k) ? window_mid(2 * k + 1) : tap_line[k];
			r.last_out = item.end_of_signal && (k == 0);
			pending_outputs.push_back(r);
		end
		// end of signal flushes the held positions raw, oldest first
		if (item.end_of_signal) begin
			first = (n >= k) ? k : n + 1;
			for (i = first; i > 0; i--) begin
				r.filtered = tap_line[i-1];
				r.last_out = (i == 1);
				pending_outputs.push_back(r);
			end
			seen_count = 0;
		end else if (seen_count < TAPS) begin
			seen_count++;
		end
	endfunction

	// result side: random backpressure
	always @(negedge clk) begin
		if (!stall_on) begin
			result_ready <= 1'b1;
		end else if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else begin
			stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
			result_ready <= (stall_left == 0);
			if (stall_left > 0) stall_left--;
		end
	end

	// compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_outputs.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected output: filtered %0d last %0b",
						$signed(result_data.filtered), result_data.last_out);
			end else begin
				want = pending_outputs.pop_front();
				if (result_data.filtered !== want.filtered ||
					result_data.last_out !== want.last_out) begin
					fail_count++;
					if (fail_count <= 10)
						$display("output %0d mismatch: filtered exp %0d got %0d, last exp %0b got %0b",
							outputs_checked, $signed(want.filtered),
							$signed(result_data.filtered), want.last_out,
							result_data.last_out);
				end
				outputs_checked++;
			end
		end
	end

	// one sample transfer, with an optional idle stretch ahead of it
	task automatic send_sample(input sample_t s, input logic eos);
		int gap;
		in_item_t item;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.sample        = s;
		item.end_of_signal = eos;
		sample_valid <= 1'b1;
		sample_data  <= item;
		do @(posedge clk); while (!sample_ready);
		advance_filter(item);
		samples_sent++;
		if (eos) signals_sent++;
		@(negedge clk);
	endtask

	// whole signal with random content
	task automatic send_signal(input int len);
		int i;
		for (i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
	endtask

	// hold off the sender until every predicted output has arrived
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// half width write, only with the block idle
	task automatic cfg_write(input logic [HALF_WIDTH_W-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cur_hw = v;
		hw_seen[v] = 1'b1;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reset value of the half width, short signals and extremes
	task automatic test_reset_half_width();
		send_sample(sample_t'(-32768), 1'b1);
		send_sample(sample_t'(32767), 1'b0);
		send_sample(sample_t'(-1), 1'b1);
		send_sample(sample_t'(32767), 1'b0);
		send_sample(sample_t'(-32768), 1'b0);
		send_sample(sample_t'(0), 1'b1);
	endtask

	// zero half width passes every sample straight through
	task automatic test_pass_through();
		cfg_write(HALF_WIDTH_W'(0));
		send_sample(sample_t'(1234), 1'b1);
		send_sample(sample_t'(-32768), 1'b0);
		send_sample(sample_t'(32767), 1'b1);
	endtask

	// widest window over a signal one longer than the window
	task automatic test_widest_window();
		int vals [16] = '{-32768, 32767, 0, -1, 1, 100, -100, 32767,
			-32768, 5, 5, 5, -7, 12, 32766, -32767};
		int i;
		cfg_write(HALF_WIDTH_W'(HALF_WIDTH_LIMIT));
		for (i = 0; i < 16; i++) send_sample(sample_t'(vals[i]), i == 15);
	endtask

	// half width changed in the middle of a signal after a full drain
	task automatic test_retune_mid_signal();
		int i;
		cfg_write(HALF_WIDTH_W'(2));
		for (i = 0; i < 6; i++) send_sample(pick_sample(), 1'b0);
		cfg_write(HALF_WIDTH_W'(6));
		for (i = 0; i < 9; i++) send_sample(pick_sample(), i == 8);
		for (i = 0; i < 4; i++) send_sample(pick_sample(), 1'b0);
		cfg_write(HALF_WIDTH_W'(1));
		for (i = 0; i < 5; i++) send_sample(pick_sample(), i == 4);
	endtask

	// random signals across a sweep of half widths
	task automatic test_random_signals();
		int plan [10] = '{2, 5, 7, 0, 3, 1, 6, 4, 7, 2};
		int p;
		int phase_count;
		int len;
		for (p = 0; p < 10; p++) begin
			cfg_write(HALF_WIDTH_W'(plan[p]));
			gaps_on  = (p % 3 != 2);
			stall_on = (p % 4 != 3);
			phase_count = 0;
			while (phase_count < 30) begin
				len = pick_len(plan[p]);
				send_signal(len);
				phase_count += len;
			end
		end
		gaps_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	// run limit
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	// main sequence
	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		sample_valid    = 1'b0;
		sample_data     = '0;
		result_ready    = 1'b0;
		cur_hw          = HALF_WIDTH_RESET;
		seen_count      = 0;
		samples_sent    = 0;
		signals_sent    = 0;
		outputs_checked = 0;
		fail_count      = 0;
		stall_left      = 0;
		gaps_on         = 1'b1;
		stall_on        = 1'b1;
		hw_seen         = '0;
		hw_seen[HALF_WIDTH_RESET] = 1'b1;
		foreach (tap_line[i]) tap_line[i] = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_half_width();
		test_pass_through();
		test_widest_window();
		test_retune_mid_signal();
		test_random_signals();

		wait_drained();
		repeat (20) @(negedge clk);

		$display("%0d samples in %0d signals, %0d filtered outputs checked, %0d failures",
			samples_sent, signals_sent, outputs_checked, fail_count);
		$display("half width settings used (bit per value): %b", hw_seen);
		if (fail_count == 0 && pending_outputs.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sliding_median_filter_core.f
rtl/core/smf_pkg.sv
rtl/core/smf_queue.sv
rtl/core/smf_front.sv
rtl/core/smf_back.sv
rtl/core/sliding_median_filter_core.sv
dv/tb_sliding_median_filter_core.sv
